// ===== rtl/uart_ab_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_ab_pkg
// Shared types, register addresses and sizes for the serial block.
// ----------------------------------------------------------------------------
package uart_ab_pkg;

  localparam int FifoDepth = 2;
  localparam int FifoAw    = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int TimerBits = 20;

  localparam logic [TimerBits-1:0] TMax = {TimerBits{1'b1}};
  localparam logic [TimerBits-1:0] PeriodReset = TimerBits'(4096);

  // operation kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // register addresses
  localparam logic [8:0] ADDR_RCSTA  = 9'h018;
  localparam logic [8:0] ADDR_TXBUF  = 9'h019;
  localparam logic [8:0] ADDR_RCBUF  = 9'h01A;
  localparam logic [8:0] ADDR_TXSTA  = 9'h098;
  localparam logic [8:0] ADDR_DIVLO  = 9'h099;
  localparam logic [8:0] ADDR_DIVHI  = 9'h09A;
  localparam logic [8:0] ADDR_BAUDCT = 9'h187;

  // one item, as carried from the front to the back
  typedef struct packed {
    kind_t      kind;
    logic [8:0] address;
    logic [7:0] write_data;
    logic       rx_pin;
  } item_t;

  // one result word
  typedef struct packed {
    logic       tx_irq;
    logic       rx_irq;
    logic       tx_pin;
    logic [7:0] read_data;
  } result_t;

  localparam int ItemBits = $bits(item_t);
  localparam int ResBits  = $bits(result_t);

endpackage

// ===== rtl/uart_ab_queue.sv =====
// ----------------------------------------------------------------------------
// uart_ab_queue
// Two-entry queue with registered outputs; full throughput, both sides stall
// independently.
// ----------------------------------------------------------------------------
module uart_ab_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [uart_ab_pkg::ItemBits-1:0] in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [uart_ab_pkg::ItemBits-1:0] out_data
);
  import uart_ab_pkg::*;

  logic [ItemBits-1:0] slot0;
  logic [ItemBits-1:0] slot1;
  logic [1:0]          count;

  logic push;
  logic pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // data slots, head always in slot0
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : in_data;
      if (push) begin
        slot1 <= in_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= in_data;
      end else begin
        slot1 <= in_data;
      end
    end
  end

endmodule

// ===== rtl/uart_ab_core.sv =====
// ----------------------------------------------------------------------------
// uart_ab_core
// Register file, receiver, transmitter, receive queue and auto-baud; carries
// out one item per cycle while its result register is free or being read.
// ----------------------------------------------------------------------------
module uart_ab_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  uart_ab_pkg::item_t    item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output uart_ab_pkg::result_t  res
);
  import uart_ab_pkg::*;

  localparam int Tb = TimerBits;

  // registers
  logic [7:0] rcsta, txsta, baudct, divlo, divhi, txbuf;
  logic       txfull;
  logic [9:0] fifo [FifoDepth];
  logic [FifoAw-1:0] head, tail;
  logic [15:0] rxsh, txsh;
  logic [3:0]  rxcnt, txcnt;
  logic [Tb-1:0] rxtmr, txtmr, period;
  logic txline, lastrx, rxirq, txirq;

  logic [7:0] rcsta_next, txsta_next, baudct_next, divlo_next, divhi_next, txbuf_next;
  logic       txfull_next;
  logic [FifoAw-1:0] head_next, tail_next;
  logic [15:0] rxsh_next, txsh_next;
  logic [3:0]  rxcnt_next, txcnt_next;
  logic [Tb-1:0] rxtmr_next, txtmr_next, period_next;
  logic txline_next, lastrx_next, rxirq_next, txirq_next;
  logic       fwe;
  logic [FifoAw-1:0] fwa;
  logic [9:0] fwd;
  logic [7:0] rd;
  logic       go;

  assign go         = item_valid && item_ready;
  assign item_ready = !res_valid || res_ready;

  function automatic logic [FifoAw-1:0] nidx(input logic [FifoAw-1:0] i);
    nidx = (32'(i) + 1 >= FifoDepth) ? '0 : i + 1'b1;
  endfunction

  // next state; mirrors one item of work
  always_comb begin
    logic before_on, before_async, after_on, after_async;
    logic empty, nine, shifted;
    logic [9:0] v, pv;
    logic [21:0] n;
    logic [Tb-1:0] np, brg;
    logic do_push, do_recomp;
    rcsta_next = rcsta; txsta_next = txsta; baudct_next = baudct;
    divlo_next = divlo; divhi_next = divhi; txbuf_next = txbuf;
    txfull_next = txfull; head_next = head; tail_next = tail;
    rxsh_next = rxsh; txsh_next = txsh; rxcnt_next = rxcnt; txcnt_next = txcnt;
    rxtmr_next = rxtmr; txtmr_next = txtmr; period_next = period;
    txline_next = txline; lastrx_next = lastrx; rxirq_next = rxirq; txirq_next = txirq;
    fwe = 1'b0; fwa = tail; fwd = '0; rd = 8'd0;
    do_push = 1'b0; pv = '0; do_recomp = 1'b0;
    v = '0; nine = 1'b0; shifted = 1'b0; n = '0; np = '0; brg = '0;
    empty = 1'b0;
    before_on    = rcsta[7];
    before_async = rcsta[7] && !txsta[4];
    after_on = 1'b0; after_async = 1'b0;

    case (item.kind)
      KIND_WRITE: begin
        case (item.address)
          ADDR_RCSTA: begin
            rcsta_next = (rcsta & 8'h07) | (item.write_data & 8'hF8);
            if (!rcsta_next[7] || !rcsta_next[4]) rcsta_next[1] = 1'b0;
          end
          ADDR_TXBUF: begin
            txbuf_next = item.write_data;
          end
          ADDR_RCBUF: begin
            fwe = 1'b1; fwa = tail; fwd = {2'b00, item.write_data};
          end
          ADDR_TXSTA: begin
            txsta_next = (txsta & 8'h02) | (item.write_data & 8'hFD);
            do_recomp  = 1'b1;
          end
          ADDR_DIVLO: begin
            divlo_next = item.write_data; do_recomp = 1'b1;
          end
          ADDR_DIVHI: begin
            divhi_next = item.write_data; do_recomp = 1'b1;
          end
          ADDR_BAUDCT: begin
            baudct_next = (baudct & 8'h64) | (item.write_data & 8'h9B);
            do_recomp   = 1'b1;
          end
          default: ;
        endcase
        // mode change on status writes
        if (item.address == ADDR_RCSTA || item.address == ADDR_TXSTA) begin
          after_on    = rcsta_next[7];
          after_async = rcsta_next[7] && !txsta_next[4];
          if (!after_on && before_on) begin
            txirq_next = 1'b0; rxirq_next = 1'b0; tail_next = head;
            txcnt_next = 4'd0; txfull_next = 1'b0;
          end else if (after_async && !before_async) begin
            txline_next = 1'b1;
          end
        end
        // transmit buffer load
        if (item.address == ADDR_TXBUF && txsta[5]) begin
          if (txcnt == 4'd0) begin
            shifted = 1'b1;
          end else begin
            txfull_next = 1'b1; txirq_next = 1'b0;
          end
        end
      end
      KIND_READ: begin
        case (item.address)
          ADDR_RCSTA:  rd = rcsta;
          ADDR_TXBUF:  rd = txbuf;
          ADDR_RCBUF: begin
            if (!rcsta[1] && !(head == tail && !rxirq)) begin
              rd = fifo[tail][7:0];
              tail_next = nidx(tail);
              if (tail_next == head) begin
                rxirq_next = 1'b0;
              end else begin
                rcsta_next[0] = fifo[tail_next][8];
                rcsta_next[2] = !fifo[tail_next][9];
              end
            end
          end
          ADDR_TXSTA:  rd = txsta;
          ADDR_DIVLO:  rd = divlo;
          ADDR_DIVHI:  rd = divhi;
          ADDR_BAUDCT: rd = baudct;
          default:     rd = 8'd0;
        endcase
      end
      KIND_TICK: begin
        if (rxtmr != TMax) rxtmr_next = rxtmr + 1'b1;
        if (txtmr != TMax) txtmr_next = txtmr + 1'b1;
        // receive edge
        if (item.rx_pin != lastrx) begin
          lastrx_next = item.rx_pin;
          if (before_async && rcsta[4]) begin
            if (baudct[1]) begin
              if (!item.rx_pin) begin
                do_push = 1'b1; pv = '0;
              end else begin
                baudct_next[1] = 1'b0;
              end
            end else if (baudct[0]) begin
              if (item.rx_pin) begin
                if (rxcnt == 4'd0) begin
                  rxtmr_next = '0; baudct_next[6] = 1'b0;
                end
                rxcnt_next = rxcnt + 1'b1;
                if (rxcnt_next == 4'd5) begin
                  brg = rxtmr_next >> 3;
                  divlo_next = brg[7:0];
                  divhi_next = brg[15:8];
                  baudct_next[0] = 1'b0;
                  baudct_next[7] = (brg >= Tb'(32'h10000));
                  do_recomp = 1'b1;
                  do_push = 1'b1; pv = '0;
                  rxcnt_next = 4'd0;
                end
              end
            end else if (!item.rx_pin && rxcnt == 4'd0) begin
              rxtmr_next = '0; baudct_next[6] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    // bit period, computed from the new register values
    if (do_recomp) begin
      n = 22'(divlo_next) + 22'd1;
      if (baudct_next[3]) n = n + (22'(divhi_next) << 8);
      n = n << 2;
      if (!txsta_next[4]) begin
        if (!txsta_next[2]) n = n << 2;
        if (!baudct_next[3]) n = n << 2;
      end
      np = (n > 22'(TMax)) ? TMax : Tb'(n);
      if (np != period) begin
        period_next = np; rxtmr_next = '0; txtmr_next = '0;
      end
    end
    if (item.kind == KIND_WRITE && item.address == ADDR_TXSTA &&
        rcsta_next[7] && !txsta_next[4] && !txsta_next[5]) begin
      txirq_next = 1'b0; txline_next = 1'b1;
    end

    // push for edge events (the receive push below cannot coincide)
    if (item.kind == KIND_TICK) begin
      // receiver sampling
      if (rcsta[7] && !txsta[4] && rcsta[4] && !baudct_next[0] && !baudct_next[1]
          && !do_push) begin
        if (rxcnt_next == 4'd0) begin
          if (!(rxtmr_next < (period_next >> 1)) && !item.rx_pin) begin
            rxtmr_next = '0; rxcnt_next = 4'd1; rxsh_next = '0;
          end
        end else if (rxtmr_next >= period_next) begin
          nine = rcsta[6];
          rxsh_next = {item.rx_pin, rxsh[15:1]};
          if (rxcnt_next == (nine ? 4'd10 : 4'd9)) begin
            if (nine) begin
              v = rxsh_next[15:6];
            end else begin
              v = {rxsh_next[15], rxsh_next[15:7]};
            end
            do_push = 1'b1; pv = v;
            rxcnt_next = 4'd0;
          end else begin
            rxtmr_next = '0; rxcnt_next = rxcnt_next + 1'b1;
          end
        end
      end
      // transmitter
      if (rcsta[7] && !txsta[4] && txsta[5] && txcnt != 4'd0 &&
          txtmr_next >= period_next) begin
        txline_next = txsh[0];
        txsh_next = txsh >> 1;
        txcnt_next = txcnt - 1'b1;
        if (txcnt_next == 4'd0) begin
          if (txfull) begin
            shifted = 1'b1;
          end else begin
            txsta_next[1] = 1'b1; txsta_next[3] = 1'b0;
          end
        end else begin
          txtmr_next = '0;
        end
      end
    end

    // shifter load
    if (shifted) begin
      if (txsta_next[3]) begin
        txsh_next = 16'h2000; txcnt_next = 4'd14;
      end else if (txsta_next[6]) begin
        txsh_next = {5'd0, 1'b1, txsta_next[0], txbuf_next, 1'b0};
        txcnt_next = 4'd11;
      end else begin
        txsh_next = {6'd0, 1'b1, txbuf_next, 1'b0};
        txcnt_next = 4'd10;
      end
      txsta_next[1] = 1'b0; txfull_next = 1'b0; txirq_next = 1'b1;
      txtmr_next = '0;
    end

    // receive queue push
    if (do_push) begin
      empty = (head == tail) && !rxirq;
      baudct_next[6] = 1'b1;
      if (!rcsta_next[1]) begin
        fwe = 1'b1; fwa = head; fwd = pv;
        if (empty) begin
          rcsta_next[0] = pv[8]; rcsta_next[2] = !pv[9];
        end
        head_next = nidx(head);
        if (head_next == tail) rcsta_next[1] = 1'b1;
        rxirq_next = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rcsta <= '0; txsta <= '0; baudct <= '0; divlo <= '0; divhi <= '0;
      txbuf <= '0; txfull <= 1'b0; head <= '0; tail <= '0;
      rxsh <= '0; txsh <= '0; rxcnt <= '0; txcnt <= '0;
      rxtmr <= '0; txtmr <= '0; period <= PeriodReset;
      txline <= 1'b1; lastrx <= 1'b1; rxirq <= 1'b0; txirq <= 1'b0;
    end else if (go) begin
      rcsta <= rcsta_next; txsta <= txsta_next; baudct <= baudct_next;
      divlo <= divlo_next; divhi <= divhi_next; txbuf <= txbuf_next;
      txfull <= txfull_next; head <= head_next; tail <= tail_next;
      rxsh <= rxsh_next; txsh <= txsh_next; rxcnt <= rxcnt_next;
      txcnt <= txcnt_next; rxtmr <= rxtmr_next; txtmr <= txtmr_next;
      period <= period_next; txline <= txline_next; lastrx <= lastrx_next;
      rxirq <= rxirq_next; txirq <= txirq_next;
    end
  end

  // receive queue storage
  always_ff @(posedge clk) begin
    if (go && fwe) begin
      fifo[fwa] <= fwd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= '{tx_irq: txirq_next, rx_irq: rxirq_next, tx_pin: txline_next,
               read_data: rd};
    end
  end

`ifndef SYNTH
  a_ovr_needs_irq: assert property (@(posedge clk) disable iff (rst)
    rcsta[1] |-> rxirq) else $error("overrun without queued data");
  a_full_needs_busy: assert property (@(posedge clk) disable iff (rst)
    txfull |-> (txcnt != 4'd0)) else $error("buffer full while shifter idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    txcnt <= 4'd14) else $error("transmit count out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res)) else $error("result changed while held");
`endif

endmodule

// ===== rtl/async_uart_with_autobaud.sv =====
// ----------------------------------------------------------------------------
// async_uart_with_autobaud
// Serial transceiver with auto-baud behind byte registers, one item per tick.
//
//   channel  dir  tdata fields (low bit first)                      tuser
//   s_axis   in   address[8:0] write_data[16:9] rx_pin[17]          kind[1:0]
//   m_axis   out  read_data[7:0] tx_pin[8] rx_irq[9] tx_irq[10]     -
//
// one item per cycle sustained while m_axis_tready is high; each item's
// result is registered in the core as the item leaves the input queue.
// rst is synchronous and active high; all control state and queues clear.
// a stalled output fills the result register, then the input queue, then
// drops s_axis_tready.
// ----------------------------------------------------------------------------
module async_uart_with_autobaud (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // address, write_data, rx_pin
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // read_data, tx_pin, rx_irq, tx_irq
);
  import uart_ab_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic [ItemBits-1:0] q_bits;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  // classify the incoming word
  always_comb begin
    in_item.kind       = kind_t'(s_axis_tuser);
    in_item.address    = s_axis_tdata[8:0];
    in_item.write_data = s_axis_tdata[16:9];
    in_item.rx_pin     = s_axis_tdata[17];
  end

  // front queue
  uart_ab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_bits)
  );

  assign q_item = item_t'(q_bits);

  // back end
  uart_ab_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {5'd0, res.tx_irq, res.rx_irq, res.tx_pin, res.read_data};

endmodule
